FILE: rtl/core/rmpb_pkg.sv
package rmpb_pkg;

    // APB register map: register i sits at byte address 4*i
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;

    typedef logic t_reg_idx;

    localparam t_reg_idx REG_OPACITY  = 1'b0;
    localparam t_reg_idx REG_USE_MASK = 1'b1;

endpackage

FILE: rtl/core/rmpb_pix_if.sv
interface rmpb_pix_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] base_red;
    logic [W-1:0] base_green;
    logic [W-1:0] base_blue;
    logic [W-1:0] base_alpha;
    logic [W-1:0] layer_red;
    logic [W-1:0] layer_green;
    logic [W-1:0] layer_blue;
    logic [W-1:0] layer_alpha;
    logic [W-1:0] mask_value;
    logic         last_in;

    modport source (
        output valid, base_red, base_green, base_blue, base_alpha,
               layer_red, layer_green, layer_blue, layer_alpha, mask_value, last_in,
        input  ready
    );

    modport sink (
        input  valid, base_red, base_green, base_blue, base_alpha,
               layer_red, layer_green, layer_blue, layer_alpha, mask_value, last_in,
        output ready
    );
endinterface

FILE: rtl/core/rmpb_res_if.sv
interface rmpb_res_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] out_red;
    logic [W-1:0] out_green;
    logic [W-1:0] out_blue;
    logic [W-1:0] out_alpha;
    logic         last_out;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, last_out,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, last_out,
        output ready
    );
endinterface

FILE: rtl/core/rmpb_cfg.sv
module rmpb_cfg #(
    parameter int N = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [rmpb_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [rmpb_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [rmpb_pkg::PDATA_W-1:0]  o_prdata,
    output logic [N-1:0]                  o_opacity,
    output logic                          o_use_mask
);

    logic [N-1:0]       r_opacity;
    logic               r_use_mask;
    logic               w_wr;
    rmpb_pkg::t_reg_idx w_idx;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_idx = i_paddr[rmpb_pkg::REG_IDX_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity  <= '1;
            r_use_mask <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                rmpb_pkg::REG_OPACITY:  r_opacity  <= i_pwdata[N-1:0];
                rmpb_pkg::REG_USE_MASK: r_use_mask <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            rmpb_pkg::REG_OPACITY:  o_prdata = rmpb_pkg::PDATA_W'(r_opacity);
            rmpb_pkg::REG_USE_MASK: o_prdata = rmpb_pkg::PDATA_W'(r_use_mask);
            default:                o_prdata = '0;
        endcase
    end

    assign o_opacity  = r_opacity;
    assign o_use_mask = r_use_mask;

endmodule

FILE: rtl/core/rmpb_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturation
// to all ones when the quotient would not fit in N bits.
module rmpb_div #(
    parameter int N     = 16,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [2*N-1:0]   i_dividend,
    input  logic [N-1:0]     i_divisor,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [N-1:0]     o_quot,
    output logic [TAG_W-1:0] o_tag
);

    logic             r_vld [0:N];
    logic [N-1:0]     r_rem [0:N];
    logic [N-1:0]     r_low [0:N];
    logic [N-1:0]     r_quo [0:N];
    logic [N-1:0]     r_dvs [0:N];
    logic             r_sat [0:N];
    logic [TAG_W-1:0] r_tag [0:N];

    // first stage: overflow check on the upper half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_dividend[2*N-1:N];
            r_low[0] <= i_dividend[N-1:0];
            r_quo[0] <= '0;
            r_dvs[0] <= i_divisor;
            r_sat[0] <= i_dividend[2*N-1:N] >= i_divisor;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        logic [N:0] w_trial;
        logic       w_ge;

        assign w_trial = {r_rem[i], r_low[i][N-1]};
        assign w_ge    = w_trial >= {1'b0, r_dvs[i]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= w_ge ? N'(w_trial - {1'b0, r_dvs[i]}) : w_trial[N-1:0];
                r_low[i+1] <= r_low[i] << 1;
                r_quo[i+1] <= {r_quo[i][N-2:0], w_ge};
                r_dvs[i+1] <= r_dvs[i];
                r_sat[i+1] <= r_sat[i];
                r_tag[i+1] <= r_tag[i];
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_quot = r_sat[N] ? '1 : r_quo[N];
    assign o_tag  = r_tag[N];

endmodule

FILE: rtl/core/rmpb_skid.sv
// Output register plus one skid entry; upstream ready is registered.
module rmpb_skid #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_vld,
    output logic [W-1:0] o_data,
    input  logic         i_ready
);

    logic         r_out_vld;
    logic [W-1:0] r_out;
    logic         r_skid_vld;
    logic [W-1:0] r_skid;
    logic         w_pop;
    logic         w_push;

    assign o_ready = !r_skid_vld;
    assign w_push  = i_vld && !r_skid_vld;
    assign w_pop   = r_out_vld && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_pop) begin
            r_out_vld <= w_push;
        end else if (w_push) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || w_pop) begin
            r_out <= i_data;
        end else begin
            r_skid <= i_data;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out;

endmodule

FILE: rtl/core/replace_mode_pixel_blend_core.sv
// Replace-mode pixel compositor.
// i_pix: one beat carries a base pixel, a layer pixel, a mask value and a
// last flag; o_res: one beat per input beat, in order, carrying the
// composited pixel and the copied last flag. Both are valid/ready channels.
// Opacity and mask enable are written over the APB port (0x0, 0x4); the
// user must write them only while the stream is idle; the block does not
// enforce this. pready is tied high and reads return the register value.
// Throughput: one pixel per cycle while o_res.ready stays high. The
// divider takes CHANNEL_BITS + 1 stages (an overflow check, then one
// quotient bit per stage); the rest of the pipeline is six multiply and
// rounding stages and the output register. A stalled receiver holds the
// output register; one more beat lands in a skid entry, after which
// i_pix.ready drops and the whole pipeline freezes in place until the
// output drains. Nothing is dropped or repeated. Reset (synchronous,
// active low) empties the pipeline and sets opacity to full and mask use off.
module replace_mode_pixel_blend_core #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rmpb_pix_if.sink                      i_pix,
    rmpb_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rmpb_pkg::PADDR_W-1:0]  paddr,
    input  logic [rmpb_pkg::PDATA_W-1:0]  pwdata,
    output logic [rmpb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int           N  = CHANNEL_BITS;
    localparam int           W2 = 2 * N;
    localparam logic [N-1:0] M  = '1;

    typedef struct packed {
        logic [2:0][N-1:0] base_c;
        logic [2:0][N-1:0] diff_c;
        logic [2:0]        neg_c;
        logic [N-1:0]      na;
        logic              last;
    } t_side;

    typedef struct packed {
        logic [N-1:0] red;
        logic [N-1:0] green;
        logic [N-1:0] blue;
        logic [N-1:0] alpha;
        logic         last;
    } t_res;

    // round(p / M) for p <= M*M
    function automatic logic [N-1:0] fx_red(input logic [W2-1:0] p);
        logic [W2-1:0] y;
        logic [W2-1:0] q0;
        logic [W2-1:0] r;
        y  = p + W2'(M >> 1);
        q0 = (y + (y >> N)) >> N;
        r  = y - ((q0 << N) - q0);
        if (r >= W2'(M)) begin
            q0 = q0 + W2'(1);
        end
        return q0[N-1:0];
    endfunction

    logic         w_en;
    logic [N-1:0] w_opacity;
    logic         w_use_mask;

    rmpb_cfg #(.N(N)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_opacity  (w_opacity),
        .o_use_mask (w_use_mask)
    );

    assign pready      = 1'b1;
    assign i_pix.ready = w_en;

    // stage 1: mask x opacity
    logic              r_s1_vld;
    logic [3:0][N-1:0] r_s1_base;
    logic [3:0][N-1:0] r_s1_layer;
    logic [W2-1:0]     r_s1_pmask;
    logic              r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_base  <= {i_pix.base_alpha, i_pix.base_blue, i_pix.base_green,
                           i_pix.base_red};
            r_s1_layer <= {i_pix.layer_alpha, i_pix.layer_blue, i_pix.layer_green,
                           i_pix.layer_red};
            r_s1_pmask <= W2'(i_pix.mask_value) * W2'(w_opacity);
            r_s1_last  <= i_pix.last_in;
        end
    end

    // stage 2: weight, differences and directions
    logic              r_s2_vld;
    logic [N-1:0]      r_s2_w;
    logic [N-1:0]      r_s2_adiff;
    logic              r_s2_aneg;
    logic [N-1:0]      r_s2_ba;
    logic [N-1:0]      r_s2_la;
    t_side             r_s2_side;
    t_side             n_s2_side;
    logic [N-1:0]      n_s2_w;

    always_comb begin
        n_s2_w = w_use_mask ? fx_red(r_s1_pmask) : w_opacity;
        n_s2_side.na   = '0;
        n_s2_side.last = r_s1_last;
        for (int c = 0; c < 3; c++) begin
            n_s2_side.base_c[c] = r_s1_base[c];
            n_s2_side.neg_c[c]  = r_s1_layer[c] < r_s1_base[c];
            n_s2_side.diff_c[c] = n_s2_side.neg_c[c] ? r_s1_base[c] - r_s1_layer[c]
                                                     : r_s1_layer[c] - r_s1_base[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_w     <= n_s2_w;
            r_s2_aneg  <= r_s1_layer[3] < r_s1_base[3];
            r_s2_adiff <= (r_s1_layer[3] < r_s1_base[3]) ? r_s1_base[3] - r_s1_layer[3]
                                                         : r_s1_layer[3] - r_s1_base[3];
            r_s2_ba    <= r_s1_base[3];
            r_s2_la    <= r_s1_layer[3];
            r_s2_side  <= n_s2_side;
        end
    end

    // stage 3: alpha step and w x layer alpha
    logic          r_s3_vld;
    logic [W2-1:0] r_s3_pa;
    logic [W2-1:0] r_s3_pn;
    logic [N-1:0]  r_s3_ba;
    logic          r_s3_aneg;
    t_side         r_s3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_pa   <= W2'(r_s2_adiff) * W2'(r_s2_w);
            r_s3_pn   <= W2'(r_s2_w) * W2'(r_s2_la);
            r_s3_ba   <= r_s2_ba;
            r_s3_aneg <= r_s2_aneg;
            r_s3_side <= r_s2_side;
        end
    end

    // stage 4: new alpha and ratio numerator
    logic         r_s4_vld;
    logic [N-1:0] r_s4_num;
    t_side        r_s4_side;
    t_side        n_s4_side;
    logic [N-1:0] w_astep;

    assign w_astep = fx_red(r_s3_pa);

    always_comb begin
        n_s4_side    = r_s3_side;
        n_s4_side.na = r_s3_aneg ? r_s3_ba - w_astep : r_s3_ba + w_astep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_en) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_num  <= fx_red(r_s3_pn);
            r_s4_side <= n_s4_side;
        end
    end

    // stage 5: dividend num*M + na/2
    logic          r_s5_vld;
    logic [W2-1:0] r_s5_dvd;
    t_side         r_s5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_dvd  <= ((W2'(r_s4_num) << N) - W2'(r_s4_num)) + W2'(r_s4_side.na >> 1);
            r_s5_side <= r_s4_side;
        end
    end

    logic         w_div_vld;
    logic [N-1:0] w_ratio;
    t_side        w_div_side;

    rmpb_div #(.N(N), .TAG_W($bits(t_side))) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_vld      (r_s5_vld),
        .i_dividend (r_s5_dvd),
        .i_divisor  (r_s5_side.na),
        .i_tag      (r_s5_side),
        .o_vld      (w_div_vld),
        .o_quot     (w_ratio),
        .o_tag      (w_div_side)
    );

    // stage 6: colour steps
    logic               r_s6_vld;
    logic [2:0][W2-1:0] r_s6_pc;
    t_side              r_s6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (w_en) begin
            r_s6_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_s6_pc[c] <= W2'(w_div_side.diff_c[c]) * W2'(w_ratio);
            end
            r_s6_side <= w_div_side;
        end
    end

    // final: round, apply step, zero alpha keeps the base colour
    logic [2:0][N-1:0] w_col;
    logic [N-1:0]      w_cstep;
    t_res              w_res;
    t_res              w_out;
    logic              w_out_vld;

    always_comb begin
        w_cstep = '0;
        for (int c = 0; c < 3; c++) begin
            w_cstep = fx_red(r_s6_pc[c]);
            if (r_s6_side.na == '0) begin
                w_col[c] = r_s6_side.base_c[c];
            end else if (r_s6_side.neg_c[c]) begin
                w_col[c] = r_s6_side.base_c[c] - w_cstep;
            end else begin
                w_col[c] = r_s6_side.base_c[c] + w_cstep;
            end
        end
        w_res.red   = w_col[0];
        w_res.green = w_col[1];
        w_res.blue  = w_col[2];
        w_res.alpha = r_s6_side.na;
        w_res.last  = r_s6_side.last;
    end

    rmpb_skid #(.W($bits(t_res))) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s6_vld),
        .i_data  (w_res),
        .o_ready (w_en),
        .o_vld   (w_out_vld),
        .o_data  (w_out),
        .i_ready (o_res.ready)
    );

    assign o_res.valid     = w_out_vld;
    assign o_res.out_red   = w_out.red;
    assign o_res.out_green = w_out.green;
    assign o_res.out_blue  = w_out.blue;
    assign o_res.out_alpha = w_out.alpha;
    assign o_res.last_out  = w_out.last;

endmodule

FILE: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int LATENCY = CB + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS = 10;
    localparam int SEGMENT_PIXELS = 115;
    localparam logic [CB-1:0] FULL = '1;

    typedef struct packed {
        logic [CB-1:0] base_red;
        logic [CB-1:0] base_green;
        logic [CB-1:0] base_blue;
        logic [CB-1:0] base_alpha;
        logic [CB-1:0] layer_red;
        logic [CB-1:0] layer_green;
        logic [CB-1:0] layer_blue;
        logic [CB-1:0] layer_alpha;
        logic [CB-1:0] mask_value;
        logic          last_in;
    } t_pixel;

    typedef struct packed {
        logic [CB-1:0] red;
        logic [CB-1:0] green;
        logic [CB-1:0] blue;
        logic [CB-1:0] alpha;
        logic          last;
    } t_blend;

    class replace_blend_scoreboard;
        logic [CB-1:0] opacity;
        logic          use_mask;
        t_blend        expected_q[$];
        int            mismatches;

        function new();
            opacity = FULL;
            use_mask = 1'b0;
            mismatches = 0;
        endfunction

        function void flag(string text);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", text);
            end
        endfunction

        // fixed-point product, round to nearest
        function logic [CB-1:0] scale(logic [CB-1:0] a, logic [CB-1:0] b);
            longint unsigned prod;
            prod = 64'(a);
            prod = prod * b + FULL / 2;
            return CB'(prod / FULL);
        endfunction

        function logic [CB-1:0] mix(logic [CB-1:0] a, logic [CB-1:0] b, logic [CB-1:0] w);
            if (b >= a) begin
                return a + scale(b - a, w);
            end
            return a - scale(a - b, w);
        endfunction

        function t_blend blend(t_pixel p);
            t_blend          r;
            logic [CB-1:0]   w;
            logic [CB-1:0]   na;
            logic [CB-1:0]   num;
            longint unsigned ratio;
            w = opacity;
            if (use_mask) begin
                w = scale(p.mask_value, opacity);
            end
            na = mix(p.base_alpha, p.layer_alpha, w);
            r.alpha = na;
            r.last = p.last_in;
            if (na == 0) begin
                r.red = p.base_red;
                r.green = p.base_green;
                r.blue = p.base_blue;
            end else begin
                num = scale(w, p.layer_alpha);
                ratio = 64'(num);
                ratio = (ratio * FULL + na / 2) / na;
                if (ratio > FULL) begin
                    ratio = FULL;
                end
                r.red = mix(p.base_red, p.layer_red, CB'(ratio));
                r.green = mix(p.base_green, p.layer_green, CB'(ratio));
                r.blue = mix(p.base_blue, p.layer_blue, CB'(ratio));
            end
            return r;
        endfunction

        function void note_pixel(t_pixel p);
            expected_q.push_back(blend(p));
        endfunction

        function void check_result(t_blend got);
            t_blend want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result: %h %h %h %h last %b",
                               got.red, got.green, got.blue, got.alpha, got.last));
                return;
            end
            want = expected_q.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha || got.last !== want.last) begin
                flag($sformatf("mismatch: expected %h %h %h %h last %b, got %h %h %h %h last %b",
                               want.red, want.green, want.blue, want.alpha, want.last,
                               got.red, got.green, got.blue, got.alpha, got.last));
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [rmpb_pkg::PADDR_W-1:0]   paddr;
    logic [rmpb_pkg::PDATA_W-1:0]   pwdata;
    logic [rmpb_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    int send_idle;
    int recv_idle;
    int cycles = 0;

    replace_blend_scoreboard sb = new();

    rmpb_pix_if #(.W(CB)) pix ();
    rmpb_res_if #(.W(CB)) res ();

    replace_mode_pixel_blend_core #(
        .CHANNEL_BITS (CB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        res.ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix.valid && pix.ready) begin
            sb.note_pixel({pix.base_red, pix.base_green, pix.base_blue, pix.base_alpha,
                           pix.layer_red, pix.layer_green, pix.layer_blue, pix.layer_alpha,
                           pix.mask_value, pix.last_in});
        end
        if (i_rst_n && res.valid && res.ready) begin
            sb.check_result({res.out_red, res.out_green, res.out_blue, res.out_alpha,
                             res.last_out});
        end
    end

    task automatic apb_write(rmpb_pkg::t_reg_idx idx, logic [rmpb_pkg::PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rmpb_pkg::PADDR_W'(idx) << rmpb_pkg::REG_IDX_LSB;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(rmpb_pkg::t_reg_idx idx,
                            output logic [rmpb_pkg::PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= rmpb_pkg::PADDR_W'(idx) << rmpb_pkg::REG_IDX_LSB;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // only called with the stream drained
    task automatic configure(logic [CB-1:0] opacity, logic use_mask);
        logic [rmpb_pkg::PDATA_W-1:0] rd;
        apb_write(rmpb_pkg::REG_OPACITY, rmpb_pkg::PDATA_W'(opacity));
        apb_write(rmpb_pkg::REG_USE_MASK, rmpb_pkg::PDATA_W'(use_mask));
        sb.opacity = opacity;
        sb.use_mask = use_mask;
        apb_read(rmpb_pkg::REG_OPACITY, rd);
        if (rd !== rmpb_pkg::PDATA_W'(opacity)) begin
            sb.flag($sformatf("opacity readback: expected %h, got %h", opacity, rd));
        end
        apb_read(rmpb_pkg::REG_USE_MASK, rd);
        if (rd !== rmpb_pkg::PDATA_W'(use_mask)) begin
            sb.flag($sformatf("use_mask readback: expected %h, got %h", use_mask, rd));
        end
    endtask

    task automatic send_pixel(t_pixel p);
        while ($urandom_range(99) < send_idle) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.base_red <= p.base_red;
        pix.base_green <= p.base_green;
        pix.base_blue <= p.base_blue;
        pix.base_alpha <= p.base_alpha;
        pix.layer_red <= p.layer_red;
        pix.layer_green <= p.layer_green;
        pix.layer_blue <= p.layer_blue;
        pix.layer_alpha <= p.layer_alpha;
        pix.mask_value <= p.mask_value;
        pix.last_in <= p.last_in;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    task automatic drain();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_pixel make_pixel(logic [CB-1:0] br, logic [CB-1:0] bg,
                                          logic [CB-1:0] bb, logic [CB-1:0] ba,
                                          logic [CB-1:0] lr, logic [CB-1:0] lg,
                                          logic [CB-1:0] lb, logic [CB-1:0] la,
                                          logic [CB-1:0] mask, logic last);
        return {br, bg, bb, ba, lr, lg, lb, la, mask, last};
    endfunction

    // biased towards the ends of the range
    function automatic logic [CB-1:0] rand_chan();
        case ($urandom_range(9))
            0: return '0;
            1: return FULL;
            2: return CB'($urandom_range(3));
            3: return FULL - CB'($urandom_range(3));
            default: return CB'($urandom_range(FULL));
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel p;
        p = make_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                       rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                       rand_chan(), $urandom_range(7) == 0);
        // both alphas transparent: colour must pass through from the base
        if ($urandom_range(15) == 0) begin
            p.base_alpha = '0;
            p.layer_alpha = '0;
        end
        return p;
    endfunction

    initial begin
        logic [CB-1:0] opacity;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix.valid = 1'b0;
        pix.base_red = '0;
        pix.base_green = '0;
        pix.base_blue = '0;
        pix.base_alpha = '0;
        pix.layer_red = '0;
        pix.layer_green = '0;
        pix.layer_blue = '0;
        pix.layer_alpha = '0;
        pix.mask_value = '0;
        pix.last_in = 1'b0;
        res.ready = 1'b0;
        send_idle = 18;
        recv_idle = 63;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full opacity, mask off
        configure(FULL, 1'b0);
        send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_pixel(make_pixel(FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 1'b1));
        send_pixel(make_pixel(16'h1234, 16'hABCD, FULL, 0, 16'h5555, 0, 16'h0F0F, 0, 0, 1'b0));
        send_pixel(make_pixel(FULL, FULL, FULL, FULL, 0, 0, 0, 0, FULL, 1'b1));
        send_pixel(make_pixel(16'h8000, 1, FULL, 0, 0, FULL, 16'h7FFF, 1, 16'h00FF, 1'b0));
        send_pixel(make_pixel(16'h2222, 16'h4444, 16'h6666, FULL, 16'h9999, 16'hBBBB,
                              16'hDDDD, FULL, 16'hA5A5, 1'b0));
        send_pixel(make_pixel(0, 0, 0, 1, FULL, FULL, FULL, 2, 0, 1'b1));
        drain();

        // half opacity with mask
        configure(16'h8000, 1'b1);
        send_pixel(make_pixel(16'h1111, 16'h2222, 16'h3333, 0, FULL, FULL, FULL, FULL, 0, 1'b0));
        send_pixel(make_pixel(0, FULL, 16'h8000, 16'h4000, FULL, 0, 16'h8001, 16'hC000,
                              FULL, 1'b0));
        send_pixel(make_pixel(FULL, 0, 16'h1000, 16'h0010, 0, FULL, 16'hF000, FULL, 1, 1'b1));
        send_pixel(make_pixel(0, 0, 0, 0, FULL, FULL, FULL, FULL, 16'h8000, 1'b0));
        send_pixel(make_pixel(FULL, FULL, FULL, FULL, 0, 0, 0, 0, FULL, 1'b0));
        send_pixel(make_pixel(16'h0001, 16'hFFFE, 16'h7FFF, 1, 16'hFFFE, 1, 16'h8000, 3,
                              16'hC000, 1'b1));
        drain();

        // zero opacity leaves the base untouched
        configure('0, 1'b0);
        send_pixel(make_pixel(16'h1357, 16'h2468, 16'h9BDF, 16'h4000, FULL, 0, FULL, FULL,
                              FULL, 1'b0));
        send_pixel(make_pixel(0, 0, 0, 0, FULL, FULL, FULL, FULL, FULL, 1'b1));
        drain();

        configure(16'h0001, 1'b1);
        send_pixel(make_pixel(0, FULL, 0, 0, FULL, 0, FULL, FULL, FULL, 1'b0));
        send_pixel(make_pixel(16'hAAAA, 16'h5555, 16'hFFFF, FULL, 0, FULL, 0, 0, 1, 1'b1));
        drain();

        configure(FULL, 1'b1);
        send_pixel(make_pixel(16'h0F0F, 16'hF0F0, 16'h00FF, 16'h8000, 16'hFF00, 16'h0FF0,
                              16'hF00F, 16'h8000, FULL, 1'b0));
        send_pixel(make_pixel(16'h0F0F, 16'hF0F0, 16'h00FF, 0, 16'hFF00, 16'h0FF0, 16'hF00F,
                              FULL, 0, 1'b1));
        drain();

        // random segments, each with its own register setting
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 4) begin
                send_idle = 18;
                recv_idle = 63;
            end else if (seg < 7) begin
                send_idle = 63;
                recv_idle = 18;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (seg % 5)
                0: opacity = FULL;
                1: opacity = '0;
                3: opacity = ($urandom_range(1) != 0) ? CB'(1) : FULL - CB'(1);
                default: opacity = CB'($urandom_range(FULL));
            endcase
            configure(opacity, seg % 2 == 1);
            repeat (SEGMENT_PIXELS) send_pixel(random_pixel());
            drain();
        end

        repeat (LATENCY + 8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rmpb_pkg.sv
rtl/core/rmpb_pix_if.sv
rtl/core/rmpb_res_if.sv
rtl/core/rmpb_cfg.sv
rtl/core/rmpb_div.sv
rtl/core/rmpb_skid.sv
rtl/core/replace_mode_pixel_blend_core.sv
sim/testbench.sv
